/* src/vff_pkg.sv */
// Shared types, widths and register codes for the venturi flow unit.
`timescale 1ns / 1ps

package vff_pkg;

  localparam int SampleBits = 10;
  localparam int SlopeW     = 24;
  localparam int OffsetW    = 32;
  localparam int GainW      = 32;
  localparam int FlowW      = 32;
  localparam int FracBits   = 16;

  localparam int ProdW  = SampleBits + 1 + SlopeW;
  localparam int DiffW  = ((ProdW > OffsetW) ? ProdW : OffsetW) + 2;
  localparam int RootW  = (DiffW + 1) / 2;
  localparam int XW     = 2 * RootW;
  localparam int RemW   = RootW + 3;
  localparam int GprodW = RootW + GainW;

  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic signed [SlopeW-1:0]  SlopeReset  = SlopeW'(256);
  localparam logic signed [OffsetW-1:0] OffsetReset = '0;
  localparam logic [GainW-1:0]          GainReset   = GainW'(65536);

  typedef enum logic [2:0] {
    RegSlopeInhInlet  = 3'd0,
    RegSlopeInhThroat = 3'd1,
    RegSlopeExhInlet  = 3'd2,
    RegSlopeExhThroat = 3'd3,
    RegOffsetInh      = 3'd4,
    RegOffsetExh      = 3'd5,
    RegFlowGain       = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [SampleBits-1:0] inhale_inlet_sample;
    logic [SampleBits-1:0] inhale_throat_sample;
    logic [SampleBits-1:0] exhale_inlet_sample;
    logic [SampleBits-1:0] exhale_throat_sample;
  } vff_req_t;

  typedef struct packed {
    logic [FlowW-1:0] inhale_flow;
    logic [FlowW-1:0] exhale_flow;
    logic             inhale_reverse;
    logic             exhale_reverse;
  } vff_rsp_t;

  typedef struct packed {
    logic signed [SlopeW-1:0]  slope_inh_inlet;
    logic signed [SlopeW-1:0]  slope_inh_throat;
    logic signed [SlopeW-1:0]  slope_exh_inlet;
    logic signed [SlopeW-1:0]  slope_exh_throat;
    logic signed [OffsetW-1:0] offset_inh;
    logic signed [OffsetW-1:0] offset_exh;
    logic [GainW-1:0]          flow_gain;
  } cfg_t;

  typedef struct packed {
    logic [XW-1:0]    x;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } root_lane_t;

  typedef struct packed {
    root_lane_t inh;
    root_lane_t exh;
    logic       rev_inh;
    logic       rev_exh;
  } root_stage_t;

endpackage

/* src/vff_regs.sv */
// APB-style register file holding calibration slopes, offsets and flow gain.
`timescale 1ns / 1ps

module vff_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vff_pkg::AddrW-1:0]  paddr,
  input  logic [vff_pkg::DataW-1:0]  pwdata,
  output logic [vff_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output vff_pkg::cfg_t              cfg_o
);

  vff_pkg::cfg_t    cfg_q;
  vff_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = vff_pkg::reg_idx_e'(paddr[vff_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_inh_inlet  <= vff_pkg::SlopeReset;
      cfg_q.slope_inh_throat <= vff_pkg::SlopeReset;
      cfg_q.slope_exh_inlet  <= vff_pkg::SlopeReset;
      cfg_q.slope_exh_throat <= vff_pkg::SlopeReset;
      cfg_q.offset_inh       <= vff_pkg::OffsetReset;
      cfg_q.offset_exh       <= vff_pkg::OffsetReset;
      cfg_q.flow_gain        <= vff_pkg::GainReset;
    end else if (wr_en) begin
      case (idx)
        vff_pkg::RegSlopeInhInlet:  cfg_q.slope_inh_inlet  <= pwdata[vff_pkg::SlopeW-1:0];
        vff_pkg::RegSlopeInhThroat: cfg_q.slope_inh_throat <= pwdata[vff_pkg::SlopeW-1:0];
        vff_pkg::RegSlopeExhInlet:  cfg_q.slope_exh_inlet  <= pwdata[vff_pkg::SlopeW-1:0];
        vff_pkg::RegSlopeExhThroat: cfg_q.slope_exh_throat <= pwdata[vff_pkg::SlopeW-1:0];
        vff_pkg::RegOffsetInh:      cfg_q.offset_inh       <= pwdata[vff_pkg::OffsetW-1:0];
        vff_pkg::RegOffsetExh:      cfg_q.offset_exh       <= pwdata[vff_pkg::OffsetW-1:0];
        vff_pkg::RegFlowGain:       cfg_q.flow_gain        <= pwdata[vff_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      vff_pkg::RegSlopeInhInlet:  prdata = vff_pkg::DataW'(cfg_q.slope_inh_inlet);
      vff_pkg::RegSlopeInhThroat: prdata = vff_pkg::DataW'(cfg_q.slope_inh_throat);
      vff_pkg::RegSlopeExhInlet:  prdata = vff_pkg::DataW'(cfg_q.slope_exh_inlet);
      vff_pkg::RegSlopeExhThroat: prdata = vff_pkg::DataW'(cfg_q.slope_exh_throat);
      vff_pkg::RegOffsetInh:      prdata = vff_pkg::DataW'(cfg_q.offset_inh);
      vff_pkg::RegOffsetExh:      prdata = vff_pkg::DataW'(cfg_q.offset_exh);
      vff_pkg::RegFlowGain:       prdata = vff_pkg::DataW'(cfg_q.flow_gain);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* src/vff_pre.sv */
// Front stages: calibrated products, then pressure difference and root seed.
`timescale 1ns / 1ps

module vff_pre (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vff_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  input  vff_pkg::vff_req_t    in_req_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output vff_pkg::root_stage_t out_stg_o,
  input  logic                 out_ready_i
);

  localparam int ProdW = vff_pkg::ProdW;
  localparam int DiffW = vff_pkg::DiffW;
  localparam int XW    = vff_pkg::XW;

  logic                    p_valid_q;
  logic                    p_ready;
  logic signed [ProdW-1:0] pi_in_q, pi_th_q, pe_in_q, pe_th_q;
  logic signed [ProdW-1:0] pi_in_d, pi_th_d, pe_in_d, pe_th_d;

  logic                    d_valid_q;
  vff_pkg::root_stage_t    d_stg_q, d_stg_d;
  logic signed [DiffW-1:0] diff_inh, diff_exh;

  assign pi_in_d = ProdW'($signed({1'b0, in_req_i.inhale_inlet_sample}))
                 * ProdW'(cfg_i.slope_inh_inlet);
  assign pi_th_d = ProdW'($signed({1'b0, in_req_i.inhale_throat_sample}))
                 * ProdW'(cfg_i.slope_inh_throat);
  assign pe_in_d = ProdW'($signed({1'b0, in_req_i.exhale_inlet_sample}))
                 * ProdW'(cfg_i.slope_exh_inlet);
  assign pe_th_d = ProdW'($signed({1'b0, in_req_i.exhale_throat_sample}))
                 * ProdW'(cfg_i.slope_exh_throat);

  assign in_ready_o = !p_valid_q || p_ready;
  assign p_ready    = !d_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      p_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pi_in_q <= pi_in_d;
      pi_th_q <= pi_th_d;
      pe_in_q <= pe_in_d;
      pe_th_q <= pe_th_d;
    end
  end

  assign diff_inh = DiffW'(pi_in_q) - DiffW'(pi_th_q) + DiffW'(cfg_i.offset_inh);
  assign diff_exh = DiffW'(pe_in_q) - DiffW'(pe_th_q) + DiffW'(cfg_i.offset_exh);

  always_comb begin
    d_stg_d          = '0;
    d_stg_d.rev_inh  = diff_inh[DiffW-1];
    d_stg_d.rev_exh  = diff_exh[DiffW-1];
    d_stg_d.inh.x    = diff_inh[DiffW-1] ? '0 : XW'($unsigned(diff_inh));
    d_stg_d.exh.x    = diff_exh[DiffW-1] ? '0 : XW'($unsigned(diff_exh));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (p_ready) begin
      d_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q && p_ready) begin
      d_stg_q <= d_stg_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_stg_o   = d_stg_q;

endmodule

/* src/vff_root_cell.sv */
// One square-root digit cell: retires two radicand bits per lane and passes on.
`timescale 1ns / 1ps

module vff_root_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  vff_pkg::root_stage_t in_stg_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output vff_pkg::root_stage_t out_stg_o,
  input  logic                 out_ready_i
);

  localparam int XW    = vff_pkg::XW;
  localparam int RemW  = vff_pkg::RemW;
  localparam int RootW = vff_pkg::RootW;

  logic                 valid_q;
  vff_pkg::root_stage_t stg_q, stg_d;

  function automatic vff_pkg::root_lane_t digit_step(input vff_pkg::root_lane_t l);
    vff_pkg::root_lane_t r;
    logic [RemW-1:0]     rem_w;
    logic [RemW-1:0]     trial;
    logic                fits;
    rem_w  = {l.rem[RemW-3:0], l.x[XW-1:XW-2]};
    trial  = RemW'({l.root, 2'b01});
    fits   = rem_w >= trial;
    r.x    = {l.x[XW-3:0], 2'b00};
    r.rem  = fits ? (rem_w - trial) : rem_w;
    r.root = {l.root[RootW-2:0], fits};
    return r;
  endfunction

  always_comb begin
    stg_d     = in_stg_i;
    stg_d.inh = digit_step(in_stg_i.inh);
    stg_d.exh = digit_step(in_stg_i.exh);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= stg_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_stg_o   = stg_q;

endmodule

/* src/vff_post.sv */
// Back stages: root times flow gain, then scale and saturate into the result.
`timescale 1ns / 1ps

module vff_post (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vff_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  input  vff_pkg::root_stage_t in_stg_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output vff_pkg::vff_rsp_t    out_rsp_o,
  input  logic                 out_ready_i
);

  localparam int GprodW = vff_pkg::GprodW;
  localparam int FlowW  = vff_pkg::FlowW;
  localparam int Frac   = vff_pkg::FracBits;

  logic              m_valid_q;
  logic              m_ready;
  logic [GprodW-1:0] gi_q, ge_q;
  logic              ri_q, re_q;

  logic              o_valid_q;
  vff_pkg::vff_rsp_t rsp_q, rsp_d;

  assign in_ready_o = !m_valid_q || m_ready;
  assign m_ready    = !o_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      m_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gi_q <= GprodW'(in_stg_i.inh.root) * GprodW'(cfg_i.flow_gain);
      ge_q <= GprodW'(in_stg_i.exh.root) * GprodW'(cfg_i.flow_gain);
      ri_q <= in_stg_i.rev_inh;
      re_q <= in_stg_i.rev_exh;
    end
  end

  always_comb begin
    rsp_d.inhale_flow    = (|gi_q[GprodW-1:Frac+FlowW]) ? '1 : gi_q[Frac+FlowW-1:Frac];
    rsp_d.exhale_flow    = (|ge_q[GprodW-1:Frac+FlowW]) ? '1 : ge_q[Frac+FlowW-1:Frac];
    rsp_d.inhale_reverse = ri_q;
    rsp_d.exhale_reverse = re_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (m_ready) begin
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_valid_q && m_ready) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

/* src/venturi_flow_from_pressure_unit.sv */
// Top level of the two-path venturi flow unit.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   in_req_i   (vff_req_t)
//  out      source     out_valid_o / out_stall_i out_rsp_o  (vff_rsp_t)
//  cfg      sink       psel/penable/pwrite       paddr, pwdata, prdata
//
// Takes one request per cycle unless out_stall_i backs up the pipeline; the front stages
// feed a row of square-root digit cells, one cell per result bit, then the back stages.
// Every stage holds its own valid, so bubbles close up while the output stalls.
// Reset empties the pipeline and loads the default calibration.
// in_stall_o rises only when every stage is full and out_stall_i is high.
`timescale 1ns / 1ps

module venturi_flow_from_pressure_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  vff_pkg::vff_req_t         in_req_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  output vff_pkg::vff_rsp_t         out_rsp_o,
  input  logic                      out_stall_i,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vff_pkg::AddrW-1:0] paddr,
  input  logic [vff_pkg::DataW-1:0] pwdata,
  output logic [vff_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int Cells = vff_pkg::RootW;

  vff_pkg::cfg_t        cfg;
  logic                 pre_ready;
  logic                 c_valid [Cells+1];
  logic                 c_ready [Cells+1];
  vff_pkg::root_stage_t c_stg   [Cells+1];

  vff_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vff_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_ready_o  (pre_ready),
    .out_valid_o (c_valid[0]),
    .out_stg_o   (c_stg[0]),
    .out_ready_i (c_ready[0])
  );

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    vff_root_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[k]),
      .in_stg_i    (c_stg[k]),
      .in_ready_o  (c_ready[k]),
      .out_valid_o (c_valid[k+1]),
      .out_stg_o   (c_stg[k+1]),
      .out_ready_i (c_ready[k+1])
    );
  end

  vff_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (c_valid[Cells]),
    .in_stg_i    (c_stg[Cells]),
    .in_ready_o  (c_ready[Cells]),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_ready_i (!out_stall_i)
  );

  assign in_stall_o = !pre_ready;

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_inh_rev_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.inhale_reverse) |-> (out_rsp_o.inhale_flow == '0))
    else $error("inhale reverse with nonzero flow");

  a_exh_rev_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.exhale_reverse) |-> (out_rsp_o.exhale_flow == '0))
    else $error("exhale reverse with nonzero flow");

  a_drain_seam : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid[Cells] && !c_ready[Cells]) |=> c_valid[Cells])
    else $error("last root cell dropped a request");

endmodule

/* tb/sv/vff_flow_checker.sv */
`timescale 1ns / 1ps
// Checker for the venturi flow unit: tracks calibration writes, predicts and compares flows.
module vff_flow_checker
  import vff_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  vff_req_t         in_req_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  vff_rsp_t         out_rsp_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  cfg_t     calib;
  vff_rsp_t expected_flow_q[$];

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] trial;
    r = '0;
    for (int i = 23; i >= 0; i--) begin
      trial = r | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= x) r = trial;
    end
    return r;
  endfunction

  function automatic void path_flow_calc(
    input  logic [SampleBits-1:0]    inl,
    input  logic [SampleBits-1:0]    thr,
    input  logic signed [SlopeW-1:0] s_in,
    input  logic signed [SlopeW-1:0] s_th,
    input  logic signed [OffsetW-1:0] off,
    input  logic [GainW-1:0]         gain,
    output logic [FlowW-1:0]         flow,
    output logic                     rev
  );
    longint      d;
    logic [63:0] p;
    d = longint'(inl) * longint'(s_in) - longint'(thr) * longint'(s_th) + longint'(off);
    if (d < 0) begin
      flow = '0;
      rev  = 1'b1;
    end else begin
      p    = (64'(floor_root(64'(d))) * 64'(gain)) >> FracBits;
      flow = (p > 64'hFFFF_FFFF) ? '1 : p[FlowW-1:0];
      rev  = 1'b0;
    end
  endfunction

  function automatic vff_rsp_t predict_flow(input vff_req_t r, input cfg_t c);
    vff_rsp_t o;
    path_flow_calc(r.inhale_inlet_sample, r.inhale_throat_sample, c.slope_inh_inlet,
                   c.slope_inh_throat, c.offset_inh, c.flow_gain, o.inhale_flow,
                   o.inhale_reverse);
    path_flow_calc(r.exhale_inlet_sample, r.exhale_throat_sample, c.slope_exh_inlet,
                   c.slope_exh_throat, c.offset_exh, c.flow_gain, o.exhale_flow,
                   o.exhale_reverse);
    return o;
  endfunction

  task automatic check_field(input string fname, input logic [FlowW-1:0] expv,
                             input logic [FlowW-1:0] actv);
    if (actv !== expv) begin
      fail_cnt_o++;
      $display("%0t %s mismatch: expected %h, got %h", $time, fname, expv, actv);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vff_rsp_t want;
    if (!rst_ni) begin
      calib = '{SlopeReset, SlopeReset, SlopeReset, SlopeReset,
                OffsetReset, OffsetReset, GainReset};
      expected_flow_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          RegSlopeInhInlet:  calib.slope_inh_inlet  = pwdata_i[SlopeW-1:0];
          RegSlopeInhThroat: calib.slope_inh_throat = pwdata_i[SlopeW-1:0];
          RegSlopeExhInlet:  calib.slope_exh_inlet  = pwdata_i[SlopeW-1:0];
          RegSlopeExhThroat: calib.slope_exh_throat = pwdata_i[SlopeW-1:0];
          RegOffsetInh:      calib.offset_inh       = pwdata_i[OffsetW-1:0];
          RegOffsetExh:      calib.offset_exh       = pwdata_i[OffsetW-1:0];
          RegFlowGain:       calib.flow_gain        = pwdata_i[GainW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_flow_q.push_back(predict_flow(in_req_i, calib));
      if (out_valid_i && !out_stall_i) begin
        if (expected_flow_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t result with none expected: expected nothing, got %h",
                   $time, out_rsp_i);
        end else begin
          want = expected_flow_q.pop_front();
          check_field("inhale_flow", want.inhale_flow, out_rsp_i.inhale_flow);
          check_field("exhale_flow", want.exhale_flow, out_rsp_i.exhale_flow);
          check_field("inhale_reverse", FlowW'(want.inhale_reverse),
                      FlowW'(out_rsp_i.inhale_reverse));
          check_field("exhale_reverse", FlowW'(want.exhale_reverse),
                      FlowW'(out_rsp_i.exhale_reverse));
        end
      end
      pending_o = expected_flow_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the venturi flow unit: clock, reset, stimulus and verdict.
module tb_top;
  import vff_pkg::*;

  localparam int         HalfPeriod    = 6;
  localparam int         DrainCycles   = 4 + RootW + 8;
  localparam int         WatchLimit    = 5000;
  localparam int         HoldCycles    = 400;
  localparam int         ItemsPerPhase = 195;
  localparam int         RandPhases    = 8;
  localparam logic [2:0] UnusedIdx     = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  vff_req_t         in_req;
  logic             in_stall;
  logic             out_valid;
  vff_rsp_t         out_rsp;
  logic             out_stall;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int   fail_cnt;
  int   pending;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_left;
  logic hold_go;
  int   quiet;

  venturi_flow_from_pressure_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_req_i    (in_req),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_rsp_o   (out_rsp),
    .out_stall_i (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  vff_flow_checker CHK (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always #HalfPeriod clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HoldCycles;
      hold_go   = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [SampleBits-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  function automatic vff_req_t mk_req(input int a, input int b, input int c, input int d);
    return '{SampleBits'(a), SampleBits'(b), SampleBits'(c), SampleBits'(d)};
  endfunction

  function automatic vff_req_t rand_req();
    return '{rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  function automatic cfg_t rand_cfg(input bit realistic);
    cfg_t c;
    if (realistic) begin
      c.slope_inh_inlet  = SlopeW'($urandom_range(2048, 64));
      c.slope_inh_throat = SlopeW'($urandom_range(2048, 64));
      c.slope_exh_inlet  = SlopeW'($urandom_range(2048, 64));
      c.slope_exh_throat = SlopeW'($urandom_range(2048, 64));
      c.offset_inh       = OffsetW'(int'($urandom_range(200000)) - 100000);
      c.offset_exh       = OffsetW'(int'($urandom_range(200000)) - 100000);
      c.flow_gain        = GainW'($urandom_range(1 << 20, 1 << 10));
    end else begin
      c.slope_inh_inlet  = SlopeW'($urandom);
      c.slope_inh_throat = SlopeW'($urandom);
      c.slope_exh_inlet  = SlopeW'($urandom);
      c.slope_exh_throat = SlopeW'($urandom);
      c.offset_inh       = OffsetW'($urandom);
      c.offset_exh       = OffsetW'($urandom);
      c.flow_gain        = GainW'($urandom);
    end
    return c;
  endfunction

  task automatic send_req(input vff_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_cfg(input cfg_t c);
    apb_write(RegSlopeInhInlet,  {8'($urandom), c.slope_inh_inlet});
    apb_write(RegSlopeInhThroat, {8'($urandom), c.slope_inh_throat});
    apb_write(RegSlopeExhInlet,  {8'($urandom), c.slope_exh_inlet});
    apb_write(RegSlopeExhThroat, {8'($urandom), c.slope_exh_throat});
    apb_write(RegOffsetInh,      c.offset_inh);
    apb_write(RegOffsetExh,      c.offset_exh);
    apb_write(RegFlowGain,       c.flow_gain);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_req        = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    hold_go       = 1'b0;
    quiet         = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset calibration: zero, negative and full-scale differences
    send_req(mk_req(0, 0, 0, 0));
    send_req(mk_req(1023, 0, 0, 1023));
    send_req(mk_req(1023, 1023, 1023, 1023));
    send_req(mk_req(1, 0, 1, 0));
    send_req(mk_req(512, 511, 0, 1));
    send_req(mk_req(1023, 1, 2, 1022));
    settle();

    // largest slopes, offsets and gain: saturation
    load_cfg('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF});
    send_req(mk_req(1023, 0, 1023, 0));
    send_req(mk_req(0, 1023, 0, 1023));
    send_req(mk_req(0, 0, 0, 0));
    send_req(mk_req(1023, 1023, 512, 513));
    settle();

    // most negative slopes and offsets, zero gain
    load_cfg('{24'h800000, 24'h800000, 24'h800000, 24'h800000,
               32'h80000000, 32'h80000000, 32'h0});
    send_req(mk_req(0, 1023, 1023, 0));
    send_req(mk_req(0, 0, 0, 0));
    send_req(mk_req(1023, 0, 0, 1023));
    send_req(mk_req(1023, 1023, 1, 1));
    settle();

    // opposite-sign slopes per path; write to an unused index must be dropped
    load_cfg('{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
               32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF});
    apb_write(UnusedIdx, $urandom);
    send_req(mk_req(1023, 1023, 0, 0));
    send_req(mk_req(0, 0, 1023, 1023));
    send_req(mk_req(1023, 0, 0, 1023));
    send_req(mk_req(0, 1023, 1023, 0));
    settle();

    for (int p = 0; p < RandPhases; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      load_cfg(rand_cfg(p % 2 == 0));
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 0 && i == 20) hold_go = 1'b1;
        send_req(rand_req());
      end
      settle();
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
